// ===== rtl/slc_pkg.sv =====
// Shared constants, codes and types of the set-associative LRU cache model.
// Used by slc_lookup and by the top level set_associative_lru_cache_sim.
// No dependencies.
package slc_pkg;

  // Default sizing, handed to the top level parameters.
  localparam int DEF_MAX_SET_BITS = 8;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_ADDR_BITS    = 48;

  // Statistics counters.
  localparam int          CNT_W   = 32;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  // Access commands.
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;

  // Configuration register indexes and widths.
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;
  localparam int         CFG_DW         = 5;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // Outcome flags of one set lookup.
  typedef struct packed {
    logic hit;
    logic evict;
  } lk_res_t;

endpackage

// ===== rtl/slc_store.sv =====
// Set storage of the cache: a tag memory and a valid/age memory, one row per set,
// read through registered outputs, plus a flip-flop per row that marks rows written
// since reset. No package dependencies.
module slc_store #(
  parameter int ROWS   = 256,
  parameter int SET_IW = 8,
  parameter int WAYS   = 8,
  parameter int WAY_W  = 3,
  parameter int AGE_W  = 3,
  parameter int TAG_W  = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Read port
  input  logic                             rd_en,
  input  logic [SET_IW-1:0]                rd_set,
  output logic [WAYS-1:0]                  rd_valid,
  output logic [WAYS-1:0][AGE_W-1:0]       rd_ages,
  output logic [WAYS-1:0][TAG_W-1:0]       rd_tags,
  // Write port
  input  logic                             wr_en,
  input  logic [SET_IW-1:0]                wr_set,
  input  logic [WAY_W-1:0]                 wr_way,
  input  logic [TAG_W-1:0]                 wr_tag,
  input  logic [WAYS-1:0]                  wr_valid,
  input  logic [WAYS-1:0][AGE_W-1:0]       wr_ages
);

  logic [WAYS-1:0][TAG_W-1:0] tag_mem  [ROWS];
  logic [WAYS-1:0][AGE_W:0]   meta_mem [ROWS];

  logic [ROWS-1:0]            row_ok_r;
  logic                       rd_ok_r;
  logic [WAYS-1:0][AGE_W:0]   rd_meta_r;
  logic [WAYS-1:0][TAG_W-1:0] rd_tags_r;
  logic [WAYS-1:0][AGE_W:0]   wr_meta;

  // Pack each way as {valid, age}.
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      wr_meta[i] = {wr_valid[i], wr_ages[i]};
    end
  end

  // Tag memory: only the accessed way of a row is written.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_set][wr_way] <= wr_tag;
    end
    if (rd_en) begin
      rd_tags_r <= tag_mem[rd_set];
    end
  end

  // Valid/age memory: the whole row is written back.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      meta_mem[wr_set] <= wr_meta;
    end
    if (rd_en) begin
      rd_meta_r <= meta_mem[rd_set];
    end
  end

  // Row-written marks: a row never written since reset reads as empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r <= '0;
      rd_ok_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_ok_r[wr_set] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= row_ok_r[rd_set];
      end
    end
  end

  // Unpack the registered row, masked by its written mark.
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      rd_valid[i] = rd_ok_r & rd_meta_r[i][AGE_W];
      rd_ages[i]  = rd_ok_r ? rd_meta_r[i][AGE_W-1:0] : '0;
    end
  end

  assign rd_tags = rd_tags_r;

endmodule

// ===== rtl/slc_lookup.sv =====
// Lookup and replacement logic for one set row: tag match, fill or LRU victim,
// and the updated valid bits and age ranks to write back. Depends on slc_pkg.
module slc_lookup
  import slc_pkg::*;
#(
  parameter int WAYS   = 8,
  parameter int WAY_W  = 3,
  parameter int AGE_W  = 3,
  parameter int WCNT_W = 4,
  parameter int TAG_W  = 48
) (
  input  logic [WCNT_W-1:0]          ways_eff,
  input  logic [WAYS-1:0]            valid,
  input  logic [WAYS-1:0][AGE_W-1:0] ages,
  input  logic [WAYS-1:0][TAG_W-1:0] tags,
  input  logic [TAG_W-1:0]           tag,
  output lk_res_t                    res,
  output logic [WAY_W-1:0]           way,
  output logic [WAYS-1:0]            new_valid,
  output logic [WAYS-1:0][AGE_W-1:0] new_ages
);

  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

  always_comb begin
    logic [WAYS-1:0]  in_use;
    logic [WAYS-1:0]  match;
    logic [WAYS-1:0]  free;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] vic_way;
    logic [WAY_W-1:0] sel;
    logic [AGE_W-1:0] best;
    logic [AGE_W-1:0] old;
    logic             any_hit;
    logic             any_free;
    logic             was_valid;

    // Ways in use, tag matches and empty ways.
    for (int i = 0; i < WAYS; i++) begin
      in_use[i] = ways_eff > WCNT_W'(i);
      match[i]  = in_use[i] & valid[i] & (tags[i] == tag);
      free[i]   = in_use[i] & ~valid[i];
    end
    any_hit  = |match;
    any_free = |free;

    // Lowest matching way and lowest empty way.
    hit_way  = '0;
    free_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_way = WAY_W'(i);
      end
      if (free[i]) begin
        free_way = WAY_W'(i);
      end
    end

    // Oldest way in use; on a tie the highest numbered one wins.
    best    = '0;
    vic_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (in_use[i] && (ages[i] >= best)) begin
        best    = ages[i];
        vic_way = WAY_W'(i);
      end
    end

    if (any_hit) begin
      sel = hit_way;
    end else if (any_free) begin
      sel = free_way;
    end else begin
      sel = vic_way;
    end
    was_valid = any_hit | ~any_free;
    old       = ages[sel];

    // Recency: accessed way becomes youngest; younger ways age, all on a fill.
    for (int i = 0; i < WAYS; i++) begin
      new_ages[i] = ages[i];
      if (WAY_W'(i) == sel) begin
        new_ages[i] = '0;
      end else if (in_use[i] && valid[i] && (!was_valid || (ages[i] < old)) &&
                   (ages[i] < AGE_MAX)) begin
        new_ages[i] = ages[i] + AGE_W'(1);
      end
      new_valid[i] = valid[i] | (WAY_W'(i) == sel);
    end

    way       = sel;
    res.hit   = any_hit;
    res.evict = ~any_hit & ~any_free;
  end

endmodule

// ===== rtl/set_associative_lru_cache_sim.sv =====
// Set-associative cache simulator with least-recently-used replacement. Each
// request carries a command (load, store or modify) and a byte address; the block
// splits the address by the configured block and set bit counts, looks the tag up
// in the selected set and returns one result with the hit, eviction and way of the
// first access and the saturating hit, miss and eviction totals. The cycle in which
// a request is accepted issues the read of its set row, and the lookup state that
// follows evaluates the row and writes it back; no new request is accepted before
// the write-back, so each request ends before the next. A modify needs no second pass,
// since its store always hits the line just touched. A held result stalls the
// write-back cycle until the output register frees up. Valid state is tracked by
// one flip-flop per set row, so there is no clearing pass after reset.
// Depends on slc_pkg, slc_store and slc_lookup.
module set_associative_lru_cache_sim
  import slc_pkg::*;
#(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int ADDR_BITS    = DEF_ADDR_BITS,
  localparam int IN_DW       = ((ADDR_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // Configuration write port
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  // Request stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // address, then zero padding
  input  logic [1:0]        in_tuser,   // command
  // Result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  // was_hit, was_evicted, used_way[2:0], hit_total[31:0], miss_total[31:0],
  // eviction_total[31:0], then zero padding
  output logic [103:0]      out_tdata
);

  localparam int ROWS   = 1 << MAX_SET_BITS;
  localparam int SET_IW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int AGE_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W  = AGE_W;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);

  // Configuration registers.
  logic [3:0] set_bits_r;
  logic [4:0] block_bits_r;
  logic [3:0] ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= 4'd4;
      block_bits_r <= 5'd4;
      ways_r       <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_BITS:   set_bits_r   <= cfg_wdata[3:0];
        REG_BLOCK_BITS: block_bits_r <= cfg_wdata[4:0];
        REG_WAYS:       ways_r       <= cfg_wdata[3:0];
        default:        ;
      endcase
    end
  end

  // Effective split and associativity.
  logic [4:0]        sb_eff;
  logic [5:0]        tag_shift;
  logic [5:0]        ways6;
  logic [WCNT_W-1:0] ways_eff;

  always_comb begin
    sb_eff = ({1'b0, set_bits_r} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                      : {1'b0, set_bits_r};
    tag_shift = {1'b0, block_bits_r} + {1'b0, sb_eff};
    ways6 = {2'b00, ways_r};
    if (ways6 == 6'd0) begin
      ways_eff = WCNT_W'(1);
    end else if (ways6 > 6'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways6);
    end
  end

  // Address split of the incoming request.
  logic [ADDR_BITS-1:0] in_addr;
  logic [ADDR_BITS-1:0] addr_sh;
  logic [SET_IW-1:0]    set_mask;
  logic [SET_IW-1:0]    in_set;
  logic [ADDR_BITS-1:0] in_tag;

  assign in_addr  = in_tdata[ADDR_BITS-1:0];
  assign addr_sh  = in_addr >> block_bits_r;
  assign set_mask = ~({SET_IW{1'b1}} << sb_eff);
  assign in_set   = addr_sh[SET_IW-1:0] & set_mask;
  assign in_tag   = in_addr >> tag_shift;

  // Request registers.
  logic [1:0]           cmd_r;
  logic [SET_IW-1:0]    set_r;
  logic [ADDR_BITS-1:0] tag_r;

  // Sequencer.
  state_t state_r, state_nxt;
  logic   accept;
  logic   out_load;
  logic   mem_we;
  logic   acc_ok;

  assign acc_ok = (cmd_r == CMD_LOAD) || (cmd_r == CMD_STORE) || (cmd_r == CMD_MODIFY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!out_tvalid || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign accept = in_tvalid & in_tready;
  assign mem_we = out_load & acc_ok;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_tuser;
      set_r <= in_set;
      tag_r <= in_tag;
    end
  end

  // Set storage and lookup.
  logic [MAX_WAYS-1:0]                rd_valid;
  logic [MAX_WAYS-1:0][AGE_W-1:0]     rd_ages;
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] rd_tags;
  lk_res_t                            lk_res;
  logic [WAY_W-1:0]                   lk_way;
  logic [MAX_WAYS-1:0]                lk_valid;
  logic [MAX_WAYS-1:0][AGE_W-1:0]     lk_ages;

  slc_store #(
    .ROWS   (ROWS),
    .SET_IW (SET_IW),
    .WAYS   (MAX_WAYS),
    .WAY_W  (WAY_W),
    .AGE_W  (AGE_W),
    .TAG_W  (ADDR_BITS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_set   (in_set),
    .rd_valid (rd_valid),
    .rd_ages  (rd_ages),
    .rd_tags  (rd_tags),
    .wr_en    (mem_we),
    .wr_set   (set_r),
    .wr_way   (lk_way),
    .wr_tag   (tag_r),
    .wr_valid (lk_valid),
    .wr_ages  (lk_ages)
  );

  slc_lookup #(
    .WAYS   (MAX_WAYS),
    .WAY_W  (WAY_W),
    .AGE_W  (AGE_W),
    .WCNT_W (WCNT_W),
    .TAG_W  (ADDR_BITS)
  ) u_lookup (
    .ways_eff  (ways_eff),
    .valid     (rd_valid),
    .ages      (rd_ages),
    .tags      (rd_tags),
    .tag       (tag_r),
    .res       (lk_res),
    .way       (lk_way),
    .new_valid (lk_valid),
    .new_ages  (lk_ages)
  );

  // Saturating add of a small increment.
  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] v, logic [1:0] d);
    logic [CNT_W:0] s;
    s = {1'b0, v} + (CNT_W + 1)'(d);
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

  // Statistics counters; the store half of a modify always counts as a hit.
  logic [CNT_W-1:0] hit_r, miss_r, evt_r;
  logic [1:0]       hit_inc;
  logic [1:0]       miss_inc;
  logic [1:0]       evt_inc;

  always_comb begin
    hit_inc  = {1'b0, acc_ok & lk_res.hit} + {1'b0, cmd_r == CMD_MODIFY};
    miss_inc = {1'b0, acc_ok & ~lk_res.hit};
    evt_inc  = {1'b0, acc_ok & lk_res.evict};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= '0;
      miss_r <= '0;
      evt_r  <= '0;
    end else if (out_load) begin
      hit_r  <= sat_add(hit_r, hit_inc);
      miss_r <= sat_add(miss_r, miss_inc);
      evt_r  <= sat_add(evt_r, evt_inc);
    end
  end

  // Output register.
  logic       out_valid_r;
  logic       out_hit_r;
  logic       out_evict_r;
  logic [2:0] out_way_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r   <= acc_ok & lk_res.hit;
      out_evict_r <= acc_ok & lk_res.evict;
      out_way_r   <= acc_ok ? 3'(lk_way) : 3'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, evt_r, miss_r, hit_r, out_way_r, out_evict_r, out_hit_r};

  // A reported eviction always comes from a miss.
  a_evict_is_miss : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evict_r |-> !out_hit_r)
    else $error("result reports an eviction on a hit");

  // The miss total moves only when a result is loaded.
  a_miss_steady : assert property (@(posedge clk) disable iff (!rst_n)
    !out_load |=> $stable(miss_r))
    else $error("miss total changed without a result");

  // The hit total never decreases.
  a_hit_monotonic : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hit_r >= $past(hit_r))
    else $error("hit total decreased");

  // The set memory is written only in a lookup cycle that delivers a result.
  a_write_in_lookup : assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_LOOKUP) && !in_tready)
    else $error("set memory written outside a lookup");

endmodule

// ===== tb/set_associative_lru_cache_sim_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the set-associative LRU cache simulator: a scoreboard class
// mirrors valid bits, tags, age ranks and totals and checks each result in request order.
// Depends on slc_pkg and on set_associative_lru_cache_sim.
module set_associative_lru_cache_sim_tb
  import slc_pkg::*;
();

  localparam int NUM_SETS       = 1 << DEF_MAX_SET_BITS;
  localparam int NUM_LINES      = NUM_SETS * DEF_MAX_WAYS;
  localparam int OLDEST_RANK    = DEF_MAX_WAYS - 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 90;
  // Command code that the block does not know.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Fields of one result, as the block reports them.
  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [2:0]  way;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
  } access_outcome_t;

  // Mirror of the cache contents and the queue of outcomes still to arrive.
  class cache_mirror;
    bit              occupied [NUM_LINES];
    logic [47:0]     stored_tag [NUM_LINES];
    logic [2:0]      rank [NUM_LINES];
    logic [31:0]     hit_tally;
    logic [31:0]     miss_tally;
    logic [31:0]     evict_tally;
    logic [3:0]      set_bits_reg;
    logic [4:0]      block_bits_reg;
    logic [3:0]      ways_reg;
    access_outcome_t pending [$];
    int              fault_count;

    function new();
      foreach (occupied[i]) begin
        occupied[i]   = 1'b0;
        rank[i]       = '0;
        stored_tag[i] = '0;
      end
      hit_tally      = '0;
      miss_tally     = '0;
      evict_tally    = '0;
      set_bits_reg   = 4'd4;
      block_bits_reg = 5'd4;
      ways_reg       = 4'd1;
      fault_count    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_SET_BITS:   set_bits_reg   = val[3:0];
        REG_BLOCK_BITS: block_bits_reg = val;
        REG_WAYS:       ways_reg       = val[3:0];
        default: ;
      endcase
    endfunction

    // Set bits and ways as the block applies them, clipped to its sizing.
    function int live_set_bits();
      return (set_bits_reg > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(set_bits_reg);
    endfunction

    function int live_ways();
      if (ways_reg == 0) return 1;
      return (ways_reg > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(ways_reg);
    endfunction

    function void bump(inout logic [31:0] c);
      if (c != CNT_MAX) c = c + 32'd1;
    endfunction

    // Make a way the youngest; a fill of an empty way ages every other valid way.
    function void promote(int base, int w, bit was_valid, int ways);
      logic [2:0] old_rank;
      int         k;
      old_rank = rank[base + w];
      for (int i = 0; i < ways; i++) begin
        k = base + i;
        if (i != w && occupied[k] && (!was_valid || rank[k] < old_rank) &&
            rank[k] < OLDEST_RANK)
          rank[k] = rank[k] + 3'd1;
      end
      rank[base + w]     = '0;
      occupied[base + w] = 1'b1;
    endfunction

    // One access to the cache; returns the hit flag.
    function bit lookup(logic [47:0] addr, output bit evicted, output logic [2:0] way);
      int          esb;
      int          ebb;
      int          ways;
      int          base;
      int          pick;
      logic [47:0] set_idx;
      logic [47:0] tag;
      logic [2:0]  oldest;
      esb     = live_set_bits();
      ebb     = int'(block_bits_reg);
      ways    = live_ways();
      set_idx = (addr >> ebb) & ((48'd1 << esb) - 48'd1);
      tag     = addr >> (ebb + esb);
      base    = int'(set_idx) * DEF_MAX_WAYS;
      evicted = 1'b0;
      way     = '0;
      for (int i = 0; i < ways; i++) begin
        if (occupied[base + i] && stored_tag[base + i] == tag) begin
          bump(hit_tally);
          promote(base, i, 1'b1, ways);
          way = 3'(i);
          return 1'b1;
        end
      end
      bump(miss_tally);
      pick = -1;
      for (int i = 0; i < ways; i++)
        if (pick < 0 && !occupied[base + i]) pick = i;
      if (pick < 0) begin
        // Set full: the oldest way goes, the highest numbered one on a tie.
        oldest = '0;
        pick   = 0;
        for (int i = 0; i < ways; i++) begin
          if (rank[base + i] >= oldest) begin
            oldest = rank[base + i];
            pick   = i;
          end
        end
        bump(evict_tally);
        evicted = 1'b1;
        promote(base, pick, 1'b1, ways);
      end else begin
        promote(base, pick, 1'b0, ways);
      end
      stored_tag[base + pick] = tag;
      way = 3'(pick);
      return 1'b0;
    endfunction

    function void note_request(logic [1:0] cmd, logic [47:0] addr);
      access_outcome_t o;
      bit              ev;
      bit              ev2;
      logic [2:0]      w;
      logic [2:0]      w2;
      o.hit     = 1'b0;
      o.evicted = 1'b0;
      o.way     = '0;
      // An unknown command makes no access and reports the totals unchanged.
      if (cmd == CMD_LOAD || cmd == CMD_STORE || cmd == CMD_MODIFY) begin
        o.hit     = lookup(addr, ev, w);
        o.evicted = ev;
        o.way     = w;
        // The store half of a modify always hits the line just touched.
        if (cmd == CMD_MODIFY) void'(lookup(addr, ev2, w2));
      end
      o.hits      = hit_tally;
      o.misses    = miss_tally;
      o.evictions = evict_tally;
      pending.push_back(o);
    endfunction

    function void check_result(logic [103:0] d);
      access_outcome_t want;
      access_outcome_t got;
      got.hit       = d[0];
      got.evicted   = d[1];
      got.way       = d[4:2];
      got.hits      = d[36:5];
      got.misses    = d[68:37];
      got.evictions = d[100:69];
      if (pending.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("result with nothing pending: %h", d);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("mismatch: expected hit %0b evict %0b way %0d totals %0d %0d %0d",
                   want.hit, want.evicted, want.way, want.hits, want.misses,
                   want.evictions);
          $display("          got hit %0b evict %0b way %0d totals %0d %0d %0d",
                   got.hit, got.evicted, got.way, got.hits, got.misses,
                   got.evictions);
        end
      end
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [1:0]        cfg_index  = REG_SET_BITS;
  logic [CFG_DW-1:0] cfg_wdata  = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [47:0]       in_tdata   = '0;        // address
  logic [1:0]        in_tuser   = CMD_LOAD;  // command
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // was_hit, was_evicted, used_way[2:0], hit_total[31:0], miss_total[31:0],
  // eviction_total[31:0], then zero padding
  logic [103:0]      out_tdata;

  cache_mirror mirror;
  bit          idling_on   = 1'b0;
  int          sink_hold   = 0;
  int          quiet_cycles = 0;

  set_associative_lru_cache_sim dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // Note accepted requests and check accepted results.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) mirror.note_request(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) mirror.check_result(out_tdata);
  end

  // Result side stalls in bursts of random length.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold  <= sink_hold - 1;
      out_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      sink_hold  <= $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we))
      quiet_cycles <= quiet_cycles + 1;
    else
      quiet_cycles <= 0;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("set_associative_lru_cache_sim_tb NOT OK");
      $finish;
    end
  end

  // Offer one request, after an optional gap, and wait until it is taken.
  task automatic send_request(input logic [1:0] cmd, input logic [47:0] addr);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (mirror.pending.size() != 0);
  endtask

  // Write all three registers on consecutive cycles while the block is idle.
  task automatic apply_config(input logic [3:0] sb, input logic [4:0] bb,
                              input logic [3:0] ways);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SET_BITS;
    cfg_wdata <= CFG_DW'(sb);
    @(posedge clk);
    mirror.write_reg(REG_SET_BITS, CFG_DW'(sb));
    cfg_index <= REG_BLOCK_BITS;
    cfg_wdata <= bb;
    @(posedge clk);
    mirror.write_reg(REG_BLOCK_BITS, bb);
    cfg_index <= REG_WAYS;
    cfg_wdata <= CFG_DW'(ways);
    @(posedge clk);
    mirror.write_reg(REG_WAYS, CFG_DW'(ways));
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [47:0] tag_pool [16];
    logic [63:0] r;
    logic [47:0] addr;
    logic [47:0] set_part;
    logic [1:0]  cmd;
    int          pool_size;
    int          set_span;
    int          esb;
    int          ebb;
    int          pick;
    mirror = new();
    repeat (2) @(posedge clk);
    rst_n     <= 1'b1;
    idling_on = 1'b1;

    // Direct mapped with the reset split: hits, conflicts, unknown command, extremes.
    send_request(CMD_LOAD,   48'h0);
    send_request(CMD_LOAD,   48'h0);
    send_request(CMD_STORE,  48'h00F);
    send_request(CMD_MODIFY, 48'h010);
    send_request(CMD_LOAD,   48'h100);
    send_request(CMD_STORE,  48'h000);
    send_request(CMD_UNUSED, 48'h000);
    send_request(CMD_LOAD,   '1);
    send_request(CMD_MODIFY, '1);
    send_request(CMD_STORE,  48'hAAAA_AAAA_AAAA);
    send_request(CMD_LOAD,   48'h5555_5555_5555);

    // Four ways in set 0: fill, refresh, then evict the oldest.
    drain();
    apply_config(4'd2, 5'd4, 4'd4);
    send_request(CMD_LOAD,   48'h000);
    send_request(CMD_LOAD,   48'h040);
    send_request(CMD_LOAD,   48'h080);
    send_request(CMD_LOAD,   48'h0C0);
    send_request(CMD_LOAD,   48'h000);
    send_request(CMD_LOAD,   48'h100);
    send_request(CMD_MODIFY, 48'h040);
    send_request(CMD_STORE,  48'h0C0);
    send_request(CMD_LOAD,   48'h080);
    send_request(CMD_UNUSED, '1);

    // Random phases: fixed splits, then random ones; a small tag pool and a few sets.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0: apply_config(4'd0,  5'd0,  4'd1);
        1: apply_config(4'd8,  5'd16, 4'd8);
        2: apply_config(4'd15, 5'd31, 4'd15);
        3: apply_config(4'd0,  5'd31, 4'd0);
        4: apply_config(4'd8,  5'd0,  4'd2);
        5: apply_config(4'd2,  5'd5,  4'd4);
        default: apply_config(4'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) :
                                                               $urandom_range(0, 8)),
                              5'(($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) :
                                                               $urandom_range(0, 16)),
                              4'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) :
                                                               $urandom_range(0, 8)));
      endcase
      esb       = mirror.live_set_bits();
      ebb       = int'(mirror.block_bits_reg);
      pool_size = mirror.live_ways() + int'($urandom_range(0, 3));
      set_span  = int'($urandom_range(1, 4));
      foreach (tag_pool[i]) begin
        r = {$urandom, $urandom};
        tag_pool[i] = $urandom_range(0, 1) ? r[47:0] : {44'd0, r[3:0]};
      end
      if (phase == NUM_PHASES - 1) idling_on = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Once in the run the sender holds off until the block has caught up.
        if (phase == 3 && n == PHASE_ITEMS / 2) drain();
        pick = int'($urandom_range(0, 99));
        r    = {$urandom, $urandom};
        if (pick < 3)       cmd = CMD_UNUSED;
        else if (pick < 40) cmd = CMD_LOAD;
        else if (pick < 70) cmd = CMD_STORE;
        else                cmd = CMD_MODIFY;
        if ($urandom_range(0, 9) == 0) begin
          addr = r[47:0];
        end else begin
          set_part = 48'($urandom_range(0, set_span - 1));
          addr = (tag_pool[$urandom_range(0, pool_size - 1)] << (ebb + esb)) |
                 ((set_part & ((48'd1 << esb) - 48'd1)) << ebb) |
                 (r[47:0] & ((48'd1 << ebb) - 48'd1));
        end
        send_request(cmd, addr);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mirror.fault_count == 0 && mirror.pending.size() == 0)
      $display("set_associative_lru_cache_sim_tb OK");
    else
      $display("set_associative_lru_cache_sim_tb NOT OK");
    $finish;
  end

endmodule
